>>> hw/rtl/canopen_feedback_frame_decoder_unit_macros.svh
// assertion macros used by the frame decoder top level
`ifndef CANOPEN_FEEDBACK_FRAME_DECODER_UNIT_MACROS_SVH
`define CANOPEN_FEEDBACK_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define CFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame decoder check failed");
// check on every clock edge, reset included
`define CFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame decoder check failed");
`else
`define CFD_ASSERT(label, prop)
`define CFD_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> hw/rtl/cfd_pkg.sv
// types, codes and constants of the frame decoder
package cfd_pkg;

  // default node table depth
  localparam int MAX_NODES_DEF = 16;

  // register indexes of the configuration port
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_INVERT_MASK = 1'b1;

  // reset values of the registers
  localparam logic [4:0]  NODE_COUNT_RST  = 5'd2;
  localparam logic [15:0] INVERT_MASK_RST = 16'h0000;

  // function codes, identifier bits 10..7
  localparam logic [3:0] FUNC_EMCY = 4'h1;
  localparam logic [3:0] FUNC_PDO1 = 4'h3;
  localparam logic [3:0] FUNC_PDO2 = 4'h5;
  localparam logic [3:0] FUNC_PDO3 = 4'h7;
  localparam logic [3:0] FUNC_PDO4 = 4'h9;
  localparam logic [3:0] FUNC_SDO  = 4'hB;

  // frame kinds reported in tuser
  localparam logic [2:0] KIND_PDO1     = 3'd0;
  localparam logic [2:0] KIND_PDO2     = 3'd1;
  localparam logic [2:0] KIND_PDO3     = 3'd2;
  localparam logic [2:0] KIND_PDO4     = 3'd3;
  localparam logic [2:0] KIND_EMCY     = 3'd4;
  localparam logic [2:0] KIND_SDO      = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd6;
  localparam logic [2:0] KIND_NODE_ERR = 3'd7;

  // controlword commands
  localparam logic [1:0] CMD_NONE        = 2'd0;
  localparam logic [1:0] CMD_FAULT_RESET = 2'd1;
  localparam logic [1:0] CMD_SHUTDOWN    = 2'd2;
  localparam logic [1:0] CMD_ENABLE      = 2'd3;

  // recovery steps
  localparam logic [2:0] STEP_HEALTHY  = 3'd0;
  localparam logic [2:0] STEP_RESET    = 3'd1;
  localparam logic [2:0] STEP_SHUTDOWN = 3'd2;
  localparam logic [2:0] STEP_ENABLE   = 3'd3;
  localparam logic [2:0] STEP_CHECK    = 3'd4;

  // sdo reply words
  localparam logic [31:0] SDO_CTRL_ACK   = 32'h0060_4060;
  localparam logic [31:0] SDO_STATUS_ACK = 32'h0060_414B;

  // fault bit of the statusword low byte
  localparam int FAULT_BIT = 3;

  // per-node state held in one memory word
  typedef struct packed {
    logic [2:0]  step;
    logic [31:0] index_count;
    logic [7:0]  mode;
    logic [15:0] status;
    logic [15:0] follow_error;
    logic [15:0] current;
    logic [31:0] velocity;
    logic [31:0] position;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

  // captured frame as seen by the update logic
  typedef struct packed {
    logic        node_ok;
    logic        invert;
    logic [3:0]  func;
    logic [3:0]  length;
    logic [63:0] payload;
  } frame_t;

  // outcome of one frame
  typedef struct packed {
    logic        write;
    logic [2:0]  kind;
    logic [1:0]  cmd;
    node_entry_t entry;
  } update_t;

endpackage

>>> hw/rtl/cfd_ram.sv
// generic single-port-write ram with registered read
module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AddrW-1:0]      waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AddrW-1:0]      raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cfd_update.sv
// frame decode and per-node state update
module cfd_update (
  input  cfd_pkg::frame_t      frame,
  input  cfd_pkg::node_entry_t old_entry,
  output cfd_pkg::update_t     upd
);

  logic [3:0]  len_c;
  logic [63:0] data;
  logic [31:0] sdo_word;

  // bytes at or above the frame length read as zero
  always_comb begin
    len_c = (frame.length > 4'd8) ? 4'd8 : frame.length;
    for (int k = 0; k < 8; k++) begin
      data[8*k +: 8] = (4'(k) < len_c) ? frame.payload[8*k +: 8] : 8'h00;
    end
    sdo_word = data[31:0];
  end

  // decode by function code
  always_comb begin
    upd       = '0;
    upd.entry = old_entry;
    upd.cmd   = cfd_pkg::CMD_NONE;
    if (!frame.node_ok) begin
      upd.kind  = cfd_pkg::KIND_NODE_ERR;
      upd.entry = '0;
    end else begin
      unique case (frame.func)
        cfd_pkg::FUNC_PDO1: begin
          upd.write          = 1'b1;
          upd.kind           = cfd_pkg::KIND_PDO1;
          upd.entry.position = frame.invert ? -frame.payload[31:0] : frame.payload[31:0];
          upd.entry.velocity = frame.invert ? -frame.payload[63:32] : frame.payload[63:32];
        end
        cfd_pkg::FUNC_PDO2: begin
          upd.write              = 1'b1;
          upd.kind               = cfd_pkg::KIND_PDO2;
          upd.entry.current      = frame.invert ? -frame.payload[15:0] : frame.payload[15:0];
          upd.entry.follow_error = frame.payload[31:16];
          upd.entry.status       = frame.payload[47:32];
        end
        cfd_pkg::FUNC_PDO3: begin
          upd.write      = 1'b1;
          upd.kind       = cfd_pkg::KIND_PDO3;
          upd.entry.mode = data[7:0];
        end
        cfd_pkg::FUNC_PDO4: begin
          upd.write             = 1'b1;
          upd.kind              = cfd_pkg::KIND_PDO4;
          upd.entry.index_count = data[31:0];
        end
        cfd_pkg::FUNC_EMCY: begin
          upd.write      = 1'b1;
          upd.kind       = cfd_pkg::KIND_EMCY;
          upd.cmd        = cfd_pkg::CMD_FAULT_RESET;
          upd.entry.step = cfd_pkg::STEP_RESET;
        end
        cfd_pkg::FUNC_SDO: begin
          upd.write = 1'b1;
          upd.kind  = cfd_pkg::KIND_SDO;
          // recovery sequence driven by sdo acknowledges
          if (sdo_word == cfd_pkg::SDO_CTRL_ACK) begin
            case (old_entry.step)
              cfd_pkg::STEP_RESET: begin
                upd.entry.step = cfd_pkg::STEP_SHUTDOWN;
                upd.cmd        = cfd_pkg::CMD_SHUTDOWN;
              end
              cfd_pkg::STEP_SHUTDOWN: begin
                upd.entry.step = cfd_pkg::STEP_ENABLE;
                upd.cmd        = cfd_pkg::CMD_ENABLE;
              end
              cfd_pkg::STEP_ENABLE: begin
                upd.entry.step = cfd_pkg::STEP_CHECK;
              end
              default: begin
                upd.entry.step = old_entry.step;
              end
            endcase
          end else if (sdo_word == cfd_pkg::SDO_STATUS_ACK &&
                       old_entry.step == cfd_pkg::STEP_CHECK) begin
            if (!data[32 + cfd_pkg::FAULT_BIT]) begin
              upd.entry.step = cfd_pkg::STEP_HEALTHY;
            end else begin
              upd.entry.step = cfd_pkg::STEP_RESET;
              upd.cmd        = cfd_pkg::CMD_FAULT_RESET;
            end
          end
        end
        default: begin
          upd.kind = cfd_pkg::KIND_UNKNOWN;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/canopen_feedback_frame_decoder_unit.sv
// top level of the canopen feedback frame decoder
// Decodes one received CAN frame per input beat into per-node motor state and
// returns one result beat per frame with the node's entry after the update.
// From acceptance to result: the accept cycle reads the node's word from the
// state memory (registered read), the next cycle decodes, writes the word back
// and loads the output register, and waits there while that register is full.
// A new frame is taken once the previous one has been written back, so the
// decoder never holds two frames at once. The output register lets a frame be
// accepted while the last result still waits.
// Node state starts at zero after reset through per-node valid bits, so no
// clearing pass is needed and frames are taken straight out of reset.
`include "canopen_feedback_frame_decoder_unit_macros.svh"

module canopen_feedback_frame_decoder_unit #(
  parameter int MAX_NODES = cfd_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // input frames
  input  logic         s_tvalid,
  output logic         s_tready,
  // can_ident[10:0], frame_length[14:11], payload[78:15], zero[79]
  input  logic [79:0]  s_tdata,
  // remote_request[0]
  input  logic         s_tuser,
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  // node_number[6:0], send_command[8:7], recovery_step[11:9],
  // motor_position[43:12], motor_velocity[75:44], motor_current[91:76],
  // follow_error[107:92], status_word[123:108], operating_mode[131:124],
  // index_count[163:132], zero[167:164]
  output logic [167:0] m_tdata,
  // frame_kind[2:0]
  output logic [2:0]   m_tuser
);

  localparam int AddrW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [4:0]           node_count;
  logic [15:0]          invert_mask;
  logic [10:0]          ident;
  logic [3:0]           length;
  logic                 remote;
  logic [63:0]          payload;
  logic [MAX_NODES-1:0] valid_bits;
  logic [6:0]           node;
  logic [6:0]           node_m1;
  logic [6:0]           in_node_m1;
  logic [AddrW-1:0]     idx;
  logic [AddrW-1:0]     raddr;
  logic                 node_ok;
  logic                 out_free;
  logic                 finish;
  logic [cfd_pkg::ENTRY_W-1:0] ram_rdata;
  cfd_pkg::node_entry_t old_entry;
  cfd_pkg::frame_t      frame;
  cfd_pkg::update_t     upd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= cfd_pkg::NODE_COUNT_RST;
      invert_mask <= cfd_pkg::INVERT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfd_pkg::REG_NODE_COUNT:  node_count  <= cfg_data[4:0];
        cfd_pkg::REG_INVERT_MASK: invert_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and sequencing
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_UPDATE) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ident   <= s_tdata[10:0];
      length  <= s_tdata[14:11];
      payload <= s_tdata[78:15];
      remote  <= s_tuser;
    end
  end

  // node number checks
  assign node       = ident[6:0];
  assign node_m1    = node - 7'd1;
  assign in_node_m1 = s_tdata[6:0] - 7'd1;
  assign idx        = node_m1[AddrW-1:0];
  assign node_ok    = !remote && (node != 7'd0) &&
                      ({3'b000, node_count} >= {1'b0, node}) &&
                      (8'({1'b0, node}) <= 8'(MAX_NODES));

  // read address follows the incoming frame, then holds while stalled
  assign raddr = (state == ST_IDLE) ? in_node_m1[AddrW-1:0] : idx;

  cfd_ram #(
    .WIDTH (cfd_pkg::ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_state_ram (
    .clk   (clk),
    .we    (finish && upd.write),
    .waddr (idx),
    .wdata (upd.entry),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (finish && upd.write) begin
      valid_bits[idx] <= 1'b1;
    end
  end

  assign old_entry = valid_bits[idx] ? cfd_pkg::node_entry_t'(ram_rdata) : '0;

  // frame view for the update logic
  always_comb begin
    frame         = '0;
    frame.node_ok = node_ok;
    frame.invert  = (node_m1 < 7'd16) && invert_mask[node_m1[3:0]];
    frame.func    = ident[10:7];
    frame.length  = length;
    frame.payload = payload;
  end

  cfd_update u_update (
    .frame     (frame),
    .old_entry (old_entry),
    .upd       (upd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= upd.kind;
      m_tdata <= {4'b0000, upd.entry.index_count, upd.entry.mode, upd.entry.status,
                  upd.entry.follow_error, upd.entry.current, upd.entry.velocity,
                  upd.entry.position, upd.entry.step, upd.cmd, node};
    end
  end

  // checks
  `CFD_ASSERT(a_accept_goes_update, (s_tvalid && s_tready) |=> (state == ST_UPDATE))
  `CFD_ASSERT(a_result_held_while_stalled, (m_tvalid && !m_tready) |=> $stable(m_tdata))
  `CFD_ASSERT(a_node_err_clean, (m_tvalid && m_tuser == cfd_pkg::KIND_NODE_ERR) |-> (m_tdata[167:7] == '0))
  `CFD_ASSERT(a_write_only_when_valid, (finish && upd.write) |-> node_ok)
  `CFD_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid))

endmodule

>>> test/tb_canopen_feedback_frame_decoder_unit.sv
// self-checking testbench for the canopen feedback frame decoder
`timescale 1ns / 1ps

module tb_canopen_feedback_frame_decoder_unit;

  // function codes with no decoder of their own
  localparam logic [3:0] FUNC_NMT    = 4'h0;
  localparam logic [3:0] FUNC_UNUSED = 4'hF;

  localparam int CYCLE_LIMIT = 400000;

  // one received frame as carried on the input stream
  typedef struct packed {
    logic        rtr;
    logic [63:0] payload;
    logic [3:0]  len;
    logic [10:0] ident;
  } can_frame_t;

  // one result beat, frame kind on top of the data bits
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  pad;
    logic [31:0] index_count;
    logic [7:0]  mode;
    logic [15:0] status;
    logic [15:0] follow_error;
    logic [15:0] current;
    logic [31:0] velocity;
    logic [31:0] position;
    logic [2:0]  step;
    logic [1:0]  cmd;
    logic [6:0]  node;
  } report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = cfd_pkg::REG_NODE_COUNT;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [2:0]   m_tuser;

  canopen_feedback_frame_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  // register copies and per-node tables of the predictor
  logic [4:0]  node_count_q = cfd_pkg::NODE_COUNT_RST;
  logic [15:0] invert_q = cfd_pkg::INVERT_MASK_RST;
  logic [31:0] pos_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [31:0] vel_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [15:0] cur_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [15:0] ferr_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [15:0] stat_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [7:0]  mode_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [31:0] idx_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};
  logic [2:0]  step_tab [cfd_pkg::MAX_NODES_DEF] = '{default: '0};

  can_frame_t frames_pending[$];
  report_t    expected_reports[$];
  can_frame_t frame_on_bus;
  int         frames_queued = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  int         ready_pattern = 0;
  int         pattern_left = 0;

  // decode one frame into the tables and return the result it should give
  function automatic report_t decode_frame(input can_frame_t f);
    report_t     r;
    logic [6:0]  node;
    logic [3:0]  func;
    logic [3:0]  n;
    logic        inv;
    logic [63:0] data;
    logic [31:0] word;
    int          lim;
    int          nbytes;
    r = '0;
    node = f.ident[6:0];
    func = f.ident[10:7];
    r.node = node;
    lim = (node_count_q < cfd_pkg::MAX_NODES_DEF) ? int'(node_count_q)
                                                  : cfd_pkg::MAX_NODES_DEF;
    if (f.rtr || node < 1 || node > lim) begin
      r.kind = cfd_pkg::KIND_NODE_ERR;
      return r;
    end
    n = 4'(node - 7'd1);
    inv = invert_q[n];
    // bytes at or beyond the frame length read as zero
    nbytes = (f.len > 8) ? 8 : int'(f.len);
    data = '0;
    for (int k = 0; k < nbytes; k++) data[8*k +: 8] = f.payload[8*k +: 8];
    r.cmd = cfd_pkg::CMD_NONE;
    case (func)
      cfd_pkg::FUNC_PDO1: begin
        pos_tab[n] = inv ? 32'd0 - f.payload[31:0] : f.payload[31:0];
        vel_tab[n] = inv ? 32'd0 - f.payload[63:32] : f.payload[63:32];
        r.kind = cfd_pkg::KIND_PDO1;
      end
      cfd_pkg::FUNC_PDO2: begin
        cur_tab[n] = inv ? 16'd0 - f.payload[15:0] : f.payload[15:0];
        ferr_tab[n] = f.payload[31:16];
        stat_tab[n] = f.payload[47:32];
        r.kind = cfd_pkg::KIND_PDO2;
      end
      cfd_pkg::FUNC_PDO3: begin
        mode_tab[n] = data[7:0];
        r.kind = cfd_pkg::KIND_PDO3;
      end
      cfd_pkg::FUNC_PDO4: begin
        idx_tab[n] = data[31:0];
        r.kind = cfd_pkg::KIND_PDO4;
      end
      cfd_pkg::FUNC_EMCY: begin
        step_tab[n] = cfd_pkg::STEP_RESET;
        r.cmd = cfd_pkg::CMD_FAULT_RESET;
        r.kind = cfd_pkg::KIND_EMCY;
      end
      cfd_pkg::FUNC_SDO: begin
        word = data[31:0];
        if (word == cfd_pkg::SDO_CTRL_ACK) begin
          case (step_tab[n])
            cfd_pkg::STEP_RESET: begin
              step_tab[n] = cfd_pkg::STEP_SHUTDOWN;
              r.cmd = cfd_pkg::CMD_SHUTDOWN;
            end
            cfd_pkg::STEP_SHUTDOWN: begin
              step_tab[n] = cfd_pkg::STEP_ENABLE;
              r.cmd = cfd_pkg::CMD_ENABLE;
            end
            cfd_pkg::STEP_ENABLE: step_tab[n] = cfd_pkg::STEP_CHECK;
            default: ;
          endcase
        end else if (word == cfd_pkg::SDO_STATUS_ACK &&
                     step_tab[n] == cfd_pkg::STEP_CHECK) begin
          // fault bit still set restarts the sequence
          if (data[32 + cfd_pkg::FAULT_BIT]) begin
            step_tab[n] = cfd_pkg::STEP_RESET;
            r.cmd = cfd_pkg::CMD_FAULT_RESET;
          end else begin
            step_tab[n] = cfd_pkg::STEP_HEALTHY;
          end
        end
        r.kind = cfd_pkg::KIND_SDO;
      end
      default: r.kind = cfd_pkg::KIND_UNKNOWN;
    endcase
    r.step = step_tab[n];
    r.position = pos_tab[n];
    r.velocity = vel_tab[n];
    r.current = cur_tab[n];
    r.follow_error = ferr_tab[n];
    r.status = stat_tab[n];
    r.mode = mode_tab[n];
    r.index_count = idx_tab[n];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input driver: bursts of beats with random gaps
  always @(posedge clk) begin
    can_frame_t f;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_reports.insert(expected_reports.size(), decode_frame(frame_on_bus));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (frames_pending.size() > 0) begin
          f = frames_pending.pop_front();
          frame_on_bus = f;
          s_tdata <= {1'b0, f.payload, f.len, f.ident};
          s_tuser <= f.rtr;
          s_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each beat, stall on a changing pattern
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_reports.size() == 0) begin
          $error("result beat with no frame outstanding, kind %0d node %0d",
                 got.kind, got.node);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_kind", want.kind, got.kind);
          check_field("node_number", want.node, got.node);
          check_field("send_command", want.cmd, got.cmd);
          check_field("recovery_step", want.step, got.step);
          check_field("motor_position", want.position, got.position);
          check_field("motor_velocity", want.velocity, got.velocity);
          check_field("motor_current", want.current, got.current);
          check_field("follow_error", want.follow_error, got.follow_error);
          check_field("status_word", want.status, got.status);
          check_field("operating_mode", want.mode, got.mode);
          check_field("index_count", want.index_count, got.index_count);
        end
      end
      if (pattern_left == 0) begin
        ready_pattern = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      case (ready_pattern)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == cfd_pkg::REG_NODE_COUNT) node_count_q = value[4:0];
    else invert_q = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_frame(input logic [3:0] func, input logic [6:0] node,
                             input logic [3:0] len, input logic rtr,
                             input logic [63:0] payload);
    can_frame_t f;
    f.ident = {func, node};
    f.len = len;
    f.rtr = rtr;
    f.payload = payload;
    frames_pending.insert(frames_pending.size(), f);
    frames_queued++;
  endtask

  // wait for every result, then for the pipeline to settle
  task automatic wait_idle();
    do @(posedge clk);
    while (frames_pending.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [3:0] rand_len();
    return ($urandom_range(0, 9) < 8) ? 4'd8 : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // mostly accepted nodes, now and then any node number at all
  function automatic logic [6:0] pick_node();
    int lim;
    lim = (node_count_q < cfd_pkg::MAX_NODES_DEF) ? int'(node_count_q)
                                                  : cfd_pkg::MAX_NODES_DEF;
    if (lim > 0 && $urandom_range(0, 9) < 8) return 7'($urandom_range(1, lim));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic queue_single(input logic [6:0] node);
    logic [3:0]  func;
    logic [63:0] p;
    logic        rtr;
    case ($urandom_range(0, 7))
      0: func = cfd_pkg::FUNC_PDO1;
      1: func = cfd_pkg::FUNC_PDO2;
      2: func = cfd_pkg::FUNC_PDO3;
      3: func = cfd_pkg::FUNC_PDO4;
      4: func = cfd_pkg::FUNC_EMCY;
      5, 6: func = cfd_pkg::FUNC_SDO;
      default: func = 4'($urandom_range(0, 15));
    endcase
    p = rand_payload();
    if (func == cfd_pkg::FUNC_SDO && $urandom_range(0, 9) < 6)
      p[31:0] = $urandom_range(0, 1) ? cfd_pkg::SDO_CTRL_ACK : cfd_pkg::SDO_STATUS_ACK;
    rtr = ($urandom_range(0, 19) == 0);
    queue_frame(func, node, rand_len(), rtr, p);
  endtask

  // emergency, three control acks and a status check, with stray frames between
  task automatic queue_recovery(input logic [6:0] node);
    logic [63:0] p;
    queue_frame(cfd_pkg::FUNC_EMCY, node, 4'($urandom_range(0, 8)), 1'b0, rand_payload());
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 4) == 0) queue_single(pick_node());
      p = {$urandom, cfd_pkg::SDO_CTRL_ACK};
      queue_frame(cfd_pkg::FUNC_SDO, node, rand_len(), 1'b0, p);
    end
    p = {$urandom, cfd_pkg::SDO_STATUS_ACK};
    p[32 + cfd_pkg::FAULT_BIT] = 1'($urandom_range(0, 1));
    queue_frame(cfd_pkg::FUNC_SDO, node, rand_len(), 1'b0, p);
  endtask

  task automatic run_phase(input logic [4:0] count, input logic [15:0] mask,
                           input int frames);
    int target;
    write_reg(cfd_pkg::REG_NODE_COUNT, {11'd0, count});
    write_reg(cfd_pkg::REG_INVERT_MASK, mask);
    target = frames_queued + frames;
    while (frames_queued < target) begin
      if ($urandom_range(0, 3) == 0) queue_recovery(pick_node());
      else queue_single(pick_node());
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed frames with two nodes, node 2 inverted
    write_reg(cfd_pkg::REG_INVERT_MASK, 16'h0002);
    queue_frame(cfd_pkg::FUNC_PDO1, 7'd1, 4'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(cfd_pkg::FUNC_PDO1, 7'd2, 4'd8, 1'b0, 64'h8000_0000_8000_0000);
    queue_frame(cfd_pkg::FUNC_PDO1, 7'd2, 4'd2, 1'b0, 64'h0000_0001_7FFF_FFFF);
    queue_frame(cfd_pkg::FUNC_PDO2, 7'd2, 4'd8, 1'b0, 64'hABCD_FFFF_1234_8000);
    queue_frame(cfd_pkg::FUNC_PDO2, 7'd1, 4'd0, 1'b0, 64'h0000_0000_0000_0000);
    queue_frame(cfd_pkg::FUNC_PDO3, 7'd1, 4'd8, 1'b0, 64'h5555_5555_5555_5580);
    queue_frame(cfd_pkg::FUNC_PDO3, 7'd1, 4'd0, 1'b0, 64'h0000_0000_0000_00FF);
    queue_frame(cfd_pkg::FUNC_PDO4, 7'd2, 4'd3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(cfd_pkg::FUNC_PDO4, 7'd1, 4'd15, 1'b0, 64'h0123_4567_89AB_CDEF);
    queue_frame(cfd_pkg::FUNC_EMCY, 7'd1, 4'd0, 1'b0, 64'h0);
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd4, 1'b0, {32'hFFFF_FFFF, cfd_pkg::SDO_CTRL_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd3, 1'b0, {32'h0, cfd_pkg::SDO_CTRL_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0, {32'h0, cfd_pkg::SDO_CTRL_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0,
                {32'h0000_0008, cfd_pkg::SDO_STATUS_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0, {32'h0, cfd_pkg::SDO_CTRL_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0, {32'h0000_0008, 32'h0060_4061});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0,
                {32'h0000_0008, cfd_pkg::SDO_STATUS_ACK});
    for (int k = 0; k < 3; k++)
      queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd8, 1'b0, {32'h0, cfd_pkg::SDO_CTRL_ACK});
    queue_frame(cfd_pkg::FUNC_SDO, 7'd1, 4'd4, 1'b0,
                {32'hFFFF_FFFF, cfd_pkg::SDO_STATUS_ACK});
    queue_frame(FUNC_NMT, 7'd1, 4'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(FUNC_UNUSED, 7'd2, 4'd8, 1'b0, 64'h0);
    queue_frame(cfd_pkg::FUNC_PDO1, 7'd1, 4'd8, 1'b1, 64'h1111_1111_1111_1111);
    queue_frame(cfd_pkg::FUNC_PDO1, 7'd0, 4'd8, 1'b0, 64'h2222_2222_2222_2222);
    queue_frame(cfd_pkg::FUNC_PDO2, 7'd3, 4'd8, 1'b0, 64'h3333_3333_3333_3333);
    queue_frame(FUNC_UNUSED, 7'd127, 4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    // random phases over several register settings
    run_phase(5'd16, 16'hFFFF, 300);
    run_phase(5'd31, 16'($urandom), 300);
    run_phase(5'd0, 16'h0000, 40);
    run_phase(5'd1, 16'h0001, 150);
    run_phase(5'($urandom_range(17, 30)), 16'($urandom), 150);
    run_phase(5'($urandom_range(1, 16)), 16'($urandom), 300);
    run_phase(5'd16, 16'h0000, 250);
    run_phase(5'($urandom_range(2, 15)), 16'($urandom), 200);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
